FILE: design/phd_pkg.sv
// shared types and constants for the pack huffman stream decoder
`default_nettype none
package phd_pkg;
	localparam int LVL_W  = 5;
	localparam int CNT_W  = 9;
	localparam int CODE_W = 10;

	typedef enum logic [2:0] {
		PH_DEPTH,
		PH_COUNTS,
		PH_SYMBOLS,
		PH_DATA,
		PH_HALT
	} phase_t;

	typedef enum logic [1:0] {
		ST_SYM     = 2'd0,
		ST_EOB     = 2'd1,
		ST_CORRUPT = 2'd2,
		ST_BADHDR  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_BASE,
		CS_INNER,
		CS_BIT,
		CS_PUSH,
		CS_FLUSH
	} ctl_state_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_start;
	} byte_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		status_t    status;
		logic       last;
	} res_item_t;
endpackage
`default_nettype wire

FILE: design/phd_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module phd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                       wr_data,
	input  wire logic                                   rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                       rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

FILE: design/pack_huffman_stream_decoder_unit.sv
// top level: byte-fed pack huffman decoder, header parse, table build, bit-serial decode
// sequence: header bytes are taken in idle; the last count byte adds a table pass (bases
// up the levels, then inner counts down); a data byte takes an accept step, then the code
// shifter steps one bit per cycle, with a push per result, then a flush, plus output stalls
// (a halting result ends the bit steps early); no new byte is taken until idle again
// reset: arst_n clears the parser to wait for a depth byte; the symbol ram is not cleared
`default_nettype none
module pack_huffman_stream_decoder_unit
	import phd_pkg::*;
#(
	parameter int MAX_LEVELS   = 24,
	parameter int SYMBOL_DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_ready,
	input  wire byte_item_t byte_item,
	output logic            res_valid,
	input  wire logic       res_ready,
	output res_item_t       res_item
);
	localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int SW = (SYMBOL_DEPTH > 1) ? $clog2(SYMBOL_DEPTH) : 1;

	// control state
	ctl_state_t state_q, state_d;
	phase_t     phase_q;

	// header parse counters
	logic [LVL_W-1:0]  dm1_q;
	logic [LVL_W-1:0]  hli_q;
	logic [CNT_W-1:0]  hsi_q;
	logic [CNT_W-1:0]  total_q;

	// per-level tables, read at one index per cycle
	logic [CNT_W-1:0]  leaf_q  [MAX_LEVELS];
	logic [CNT_W-1:0]  inner_q [MAX_LEVELS];
	logic [7:0]        base_q  [MAX_LEVELS];

	// table build pass
	logic [LW-1:0]     lvl_q;
	logic [7:0]        acc_q;

	// bit-serial decode
	logic [CODE_W-1:0] pc_q;
	logic [LVL_W-1:0]  cl_q;
	logic [7:0]        sh_q;
	logic [3:0]        bits_q;

	// result staging: new result, one pending result, output register
	status_t           nr_status_q;
	logic              halt_q;
	logic              pend_v_q;
	logic [7:0]        pend_sym_q;
	status_t           pend_status_q;
	logic              res_valid_q;
	res_item_t         res_q;

	logic [7:0]        ram_rd_data;

	// accept side
	logic        acc_fire;
	phase_t      eff_phase;
	logic [7:0]  b;
	logic        depth_bad;
	logic        hli_big;
	logic [9:0]  tot_sum;
	logic [CNT_W-1:0] tot_new;
	logic        hdr_last;
	logic        too_many;
	logic [CNT_W-1:0] hsi_inc;
	logic        sym_done;
	logic        sym_wr;

	// bit step
	logic              lv_big;
	logic [LW-1:0]     lvi;
	logic [CNT_W-1:0]  inner_sel;
	logic [CNT_W-1:0]  leaf_sel;
	logic [7:0]        base_sel;
	logic [CODE_W-1:0] pcn;
	logic              hit;
	logic [CODE_W-1:0] idx;
	logic              bad_idx;
	logic [CODE_W-1:0] pos;
	logic              is_eob;
	logic              pos_big;
	logic [LVL_W-1:0]  cl_inc;
	logic              too_deep;
	logic              bit_res;
	status_t           bit_status;
	logic              bit_halt;
	logic              bit_sym;

	// output side
	logic        can_emit;
	logic        emit;
	logic        pass_last;
	logic [9:0]  inner_sum;

	assign b          = byte_item.data_byte;
	assign byte_ready = (state_q == CS_IDLE);
	assign acc_fire   = byte_valid && byte_ready;
	assign eff_phase  = byte_item.stream_start ? PH_DEPTH : phase_q;

	// header checks on the incoming byte
	assign depth_bad = (b == 8'd0) || ({1'b0, b} > 9'(MAX_LEVELS));
	assign hli_big   = ({1'b0, hli_q} >= 6'(MAX_LEVELS));
	assign tot_sum   = {1'b0, total_q} + {2'b00, b};
	assign tot_new   = (tot_sum > 10'd511) ? 9'd511 : tot_sum[CNT_W-1:0];
	assign hdr_last  = (hli_q >= dm1_q);
	assign too_many  = ({1'b0, tot_new} > 10'(SYMBOL_DEPTH));
	assign hsi_inc   = hsi_q + 9'd1;
	assign sym_done  = (hsi_inc >= total_q);
	assign sym_wr    = acc_fire && (eff_phase == PH_SYMBOLS)
		&& ({1'b0, hsi_q} < 10'(SYMBOL_DEPTH));

	// one code bit per cycle in the bit state, against the current level
	assign lv_big    = ({1'b0, cl_q} >= 6'(MAX_LEVELS));
	assign lvi       = lv_big ? '0 : cl_q[LW-1:0];
	assign inner_sel = inner_q[lvi];
	assign leaf_sel  = leaf_q[lvi];
	assign base_sel  = base_q[lvi];
	assign pcn       = {pc_q[CODE_W-2:0], sh_q[7]};
	assign hit       = (pcn >= {1'b0, inner_sel});
	assign idx       = pcn - {1'b0, inner_sel};
	assign bad_idx   = (idx >= {1'b0, leaf_sel});
	assign pos       = {2'b00, base_sel} + idx;
	assign is_eob    = (pos == {1'b0, total_q});
	assign pos_big   = (pos >= 10'(SYMBOL_DEPTH));
	assign cl_inc    = cl_q + 5'd1;
	assign too_deep  = (cl_inc > dm1_q);

	always_comb begin
		bit_res    = 1'b0;
		bit_status = ST_CORRUPT;
		priority if (lv_big) begin
			bit_res = 1'b1;
		end else if (hit) begin
			bit_res = 1'b1;
			priority if (bad_idx) begin
				bit_status = ST_CORRUPT;
			end else if (is_eob) begin
				bit_status = ST_EOB;
			end else if (pos_big) begin
				bit_status = ST_CORRUPT;
			end else begin
				bit_status = ST_SYM;
			end
		end else begin
			bit_res = too_deep;
		end
	end

	assign bit_halt = bit_res && (bit_status != ST_SYM);
	assign bit_sym  = (state_q == CS_BIT) && bit_res && (bit_status == ST_SYM);

	assign can_emit  = !res_valid_q || res_ready;
	assign emit      = ((state_q == CS_PUSH) || (state_q == CS_FLUSH)) && pend_v_q && can_emit;
	assign pass_last = (lvl_q == dm1_q[LW-1:0]);
	assign inner_sum = {1'b0, inner_q[lvl_q]} + {1'b0, leaf_q[lvl_q]};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			CS_IDLE: begin
				if (acc_fire) begin
					unique case (eff_phase)
						PH_DEPTH: begin
							if (depth_bad) begin
								state_d = CS_PUSH;
							end
						end
						PH_COUNTS: begin
							if (!hli_big && hdr_last) begin
								state_d = too_many ? CS_PUSH : CS_BASE;
							end
						end
						PH_DATA:    state_d = CS_BIT;
						PH_SYMBOLS: state_d = CS_IDLE;
						default:    state_d = CS_IDLE;
					endcase
				end
			end
			CS_BASE: begin
				if (pass_last) begin
					state_d = (dm1_q == '0) ? CS_IDLE : CS_INNER;
				end
			end
			CS_INNER: begin
				if (lvl_q == LW'(1)) begin
					state_d = CS_IDLE;
				end
			end
			CS_BIT: begin
				if (bit_res) begin
					state_d = CS_PUSH;
				end else if (bits_q == 4'd1) begin
					state_d = CS_FLUSH;
				end
			end
			CS_PUSH: begin
				if (!pend_v_q || can_emit) begin
					state_d = (halt_q || bits_q == 4'd0) ? CS_FLUSH : CS_BIT;
				end
			end
			CS_FLUSH: begin
				if (!pend_v_q || can_emit) begin
					state_d = CS_IDLE;
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// parser and decoder control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_DEPTH;
			dm1_q       <= '0;
			hli_q       <= '0;
			hsi_q       <= '0;
			total_q     <= 9'd1;
			pc_q        <= '0;
			cl_q        <= '0;
			lvl_q       <= '0;
			acc_q       <= '0;
			bits_q      <= '0;
			halt_q      <= 1'b0;
			nr_status_q <= ST_SYM;
		end else begin
			unique case (state_q)
				CS_IDLE: begin
					if (acc_fire) begin
						halt_q <= 1'b0;
						bits_q <= '0;
						unique case (eff_phase)
							PH_DEPTH: begin
								if (depth_bad) begin
									nr_status_q <= ST_BADHDR;
									halt_q      <= 1'b1;
									phase_q     <= PH_HALT;
								end else begin
									dm1_q   <= LVL_W'(b - 8'd1);
									hli_q   <= '0;
									hsi_q   <= '0;
									total_q <= 9'd1;
									pc_q    <= '0;
									cl_q    <= '0;
									phase_q <= PH_COUNTS;
								end
							end
							PH_COUNTS: begin
								if (hli_big) begin
									phase_q <= PH_HALT;
								end else begin
									total_q <= tot_new;
									if (hdr_last) begin
										if (too_many) begin
											nr_status_q <= ST_BADHDR;
											halt_q      <= 1'b1;
											phase_q     <= PH_HALT;
										end else begin
											hsi_q   <= '0;
											lvl_q   <= '0;
											acc_q   <= '0;
											phase_q <= PH_SYMBOLS;
										end
									end else begin
										hli_q <= hli_q + 5'd1;
									end
								end
							end
							PH_SYMBOLS: begin
								hsi_q <= hsi_inc;
								if (sym_done) begin
									pc_q    <= '0;
									cl_q    <= '0;
									phase_q <= PH_DATA;
								end
							end
							PH_DATA: begin
								bits_q <= 4'd8;
							end
							default: begin
								phase_q <= PH_HALT;
							end
						endcase
					end
				end
				CS_BASE: begin
					acc_q <= acc_q + leaf_q[lvl_q][7:0];
					if (!pass_last) begin
						lvl_q <= lvl_q + LW'(1);
					end
				end
				CS_INNER: begin
					lvl_q <= lvl_q - LW'(1);
				end
				CS_BIT: begin
					bits_q      <= bits_q - 4'd1;
					nr_status_q <= bit_status;
					halt_q      <= bit_halt;
					if (bit_halt) begin
						phase_q <= PH_HALT;
					end
					if (!lv_big) begin
						if (hit && bit_status == ST_SYM) begin
							pc_q <= '0;
							cl_q <= '0;
						end else begin
							pc_q <= pcn;
							if (!hit) begin
								cl_q <= cl_inc;
							end
						end
					end
				end
				CS_PUSH:  ;
				CS_FLUSH: ;
				default:  ;
			endcase
		end
	end

	// byte shifter, msb first
	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && acc_fire) begin
			sh_q <= b;
		end else if (state_q == CS_BIT) begin
			sh_q <= {sh_q[6:0], 1'b0};
		end
	end

	// level tables
	always_ff @(posedge clk) begin
		if (state_q == CS_IDLE && acc_fire && eff_phase == PH_COUNTS && !hli_big) begin
			// the last level gets the extra transmitted leaf here
			leaf_q[hli_q[LW-1:0]] <= hdr_last ? ({1'b0, b} + 9'd1) : {1'b0, b};
		end else if (state_q == CS_BASE && pass_last) begin
			// implicit end-of-block leaf
			leaf_q[lvl_q] <= leaf_q[lvl_q] + 9'd1;
		end
		if (state_q == CS_BASE) begin
			base_q[lvl_q] <= acc_q;
			if (pass_last) begin
				inner_q[lvl_q] <= '0;
			end
		end else if (state_q == CS_INNER) begin
			inner_q[lvl_q - LW'(1)] <= inner_sum[9:1];
		end
	end

	// pending result and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == CS_PUSH && (!pend_v_q || can_emit)) begin
				pend_v_q <= 1'b1;
			end else if (state_q == CS_FLUSH && can_emit) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q.symbol <= pend_sym_q;
			res_q.status <= pend_status_q;
			res_q.last   <= (state_q == CS_FLUSH);
		end
		if (state_q == CS_PUSH && (!pend_v_q || can_emit)) begin
			pend_sym_q    <= (nr_status_q == ST_SYM) ? ram_rd_data : 8'd0;
			pend_status_q <= nr_status_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	phd_ram #(
		.WIDTH(8),
		.DEPTH(SYMBOL_DEPTH)
	) u_sym_ram (
		.clk    (clk),
		.wr_en  (sym_wr),
		.wr_addr(hsi_q[SW-1:0]),
		.wr_data(b),
		.rd_en  (bit_sym),
		.rd_addr(pos[SW-1:0]),
		.rd_data(ram_rd_data)
	);

	// checks
	a_bit_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_BIT) |-> (phase_q == PH_DATA))
		else $error("bit step outside data phase");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == CS_IDLE) |-> !pend_v_q)
		else $error("pending result left at byte boundary");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COUNTS || phase_q == PH_SYMBOLS || phase_q == PH_DATA)
		|-> ({1'b0, dm1_q} < 6'(MAX_LEVELS)))
		else $error("depth out of range");

	a_halt_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && pend_status_q != ST_SYM) |-> (state_q == CS_FLUSH))
		else $error("halting result not last");
endmodule
`default_nettype wire

FILE: dv/pack_huffman_stream_decoder_unit_tb.sv
// self-checking testbench for the pack huffman stream decoder: directed and random streams
`default_nettype none
module pack_huffman_stream_decoder_unit_tb;
	import phd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LEVELS    = 24;
	localparam int SYM_SLOTS = 256;
	localparam int STALL_CAP = 2000;

	logic       clk;
	logic       arst_n;
	logic       byte_valid;
	logic       byte_ready;
	byte_item_t byte_item;
	logic       res_valid;
	logic       res_ready;
	res_item_t  res_item;

	pack_huffman_stream_decoder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// decoder state as the predictor sees it
	phase_t      dec_phase;
	int unsigned dec_last_lvl;
	int unsigned dec_lvl_idx;
	int unsigned dec_sym_idx;
	int unsigned dec_total;
	int unsigned dec_leaves [LEVELS];
	int unsigned dec_inner [LEVELS];
	int unsigned dec_base [LEVELS];
	logic [7:0]  dec_syms [SYM_SLOTS];
	int unsigned dec_code;
	int unsigned dec_depth;

	res_item_t expected_results [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        timed_out = 1'b0;
	bit        send_burst_on;
	int        send_left;

	// the tree shape that the current stream was built with, for making well-formed data
	int unsigned gen_depth;
	int unsigned gen_counts [LEVELS];
	int unsigned gen_nsym;

	function automatic void push_result(logic [7:0] sym, status_t st);
		res_item_t r;
		r.symbol = sym;
		r.status = st;
		r.last   = 1'b0;
		expected_results.push_back(r);
	endfunction

	// bases and inner counts per level are built once the last count byte is in, inner bottom-up
	function automatic void build_code_tables();
		int unsigned acc;
		acc = 0;
		dec_leaves[dec_last_lvl] = (dec_leaves[dec_last_lvl] + 1) & 9'h1FF;
		for (int l = 0; l <= dec_last_lvl; l++) begin
			dec_base[l] = acc & 8'hFF;
			acc += dec_leaves[l];
		end
		dec_leaves[dec_last_lvl] = (dec_leaves[dec_last_lvl] + 1) & 9'h1FF;
		dec_inner[dec_last_lvl] = 0;
		for (int l = dec_last_lvl; l > 0; l--)
			dec_inner[l - 1] = ((dec_inner[l] + dec_leaves[l]) / 2) & 9'h1FF;
	endfunction

	function automatic void predict_byte(byte_item_t it);
		int unsigned b;
		int          first_new;
		int unsigned lv;
		int unsigned idx;
		int unsigned pos;
		b = it.data_byte;
		first_new = expected_results.size();
		if (it.stream_start)
			dec_phase = PH_DEPTH;
		case (dec_phase)
			PH_DEPTH: begin
				if (b < 1 || b > LEVELS) begin
					push_result(8'd0, ST_BADHDR);
					dec_phase = PH_HALT;
				end else begin
					dec_last_lvl = b - 1;
					dec_lvl_idx  = 0;
					dec_sym_idx  = 0;
					dec_total    = 1;
					dec_code     = 0;
					dec_depth    = 0;
					dec_phase    = PH_COUNTS;
				end
			end
			PH_COUNTS: begin
				dec_leaves[dec_lvl_idx] = b;
				dec_total += b;
				if (dec_total > 511)
					dec_total = 511;
				if (dec_lvl_idx >= dec_last_lvl) begin
					if (dec_total > SYM_SLOTS) begin
						push_result(8'd0, ST_BADHDR);
						dec_phase = PH_HALT;
					end else begin
						build_code_tables();
						dec_sym_idx = 0;
						dec_phase   = PH_SYMBOLS;
					end
				end else begin
					dec_lvl_idx++;
				end
			end
			PH_SYMBOLS: begin
				if (dec_sym_idx < SYM_SLOTS)
					dec_syms[dec_sym_idx] = b[7:0];
				dec_sym_idx++;
				if (dec_sym_idx >= dec_total) begin
					dec_code  = 0;
					dec_depth = 0;
					dec_phase = PH_DATA;
				end
			end
			PH_DATA: begin
				// one code bit at a time, msb first; a halting result drops the rest of the byte
				for (int i = 7; i >= 0 && dec_phase == PH_DATA; i--) begin
					lv = dec_depth;
					if (lv >= LEVELS) begin
						push_result(8'd0, ST_CORRUPT);
						dec_phase = PH_HALT;
						break;
					end
					dec_code = ((dec_code << 1) | ((b >> i) & 1)) & 10'h3FF;
					if (dec_code >= dec_inner[lv]) begin
						idx = dec_code - dec_inner[lv];
						if (idx >= dec_leaves[lv]) begin
							push_result(8'd0, ST_CORRUPT);
							dec_phase = PH_HALT;
							break;
						end
						pos = dec_base[lv] + idx;
						if (pos == dec_total) begin
							push_result(8'd0, ST_EOB);
							dec_phase = PH_HALT;
							break;
						end
						if (pos >= SYM_SLOTS) begin
							push_result(8'd0, ST_CORRUPT);
							dec_phase = PH_HALT;
							break;
						end
						push_result(dec_syms[pos], ST_SYM);
						dec_code  = 0;
						dec_depth = 0;
					end else begin
						dec_depth = (dec_depth + 1) & 5'h1F;
						if (dec_depth > dec_last_lvl) begin
							push_result(8'd0, ST_CORRUPT);
							dec_phase = PH_HALT;
							break;
						end
					end
				end
			end
			default: dec_phase = PH_HALT;
		endcase
		if (expected_results.size() > first_new)
			expected_results[$].last = 1'b1;
	endfunction

	// send one byte; bursts of random length with random gaps between them
	task automatic send_byte(logic [7:0] data, logic start);
		byte_item_t it;
		int         gap;
		it.data_byte    = data;
		it.stream_start = start;
		if (send_left == 0) begin
			send_left = $urandom_range(1, 12);
			send_burst_on = ($urandom_range(0, 3) != 0);
			gap = send_burst_on ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		send_left--;
		predict_byte(it);
		byte_valid <= 1'b1;
		byte_item  <= it;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
	endtask

	task automatic wait_drained();
		byte_valid <= 1'b0;
		while (expected_results.size() != 0 && !timed_out) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// header for a tree of the given level counts; count bytes go out as sent (last minus two)
	task automatic send_header(int unsigned depth, bit randsyms);
		send_byte(depth[7:0], 1'b1);
		for (int l = 0; l < depth; l++)
			send_byte(gen_counts[l][7:0], 1'b0);
		gen_depth = depth;
		gen_nsym = 1;
		for (int l = 0; l < depth; l++)
			gen_nsym += gen_counts[l];
		for (int s = 0; s < gen_nsym; s++)
			send_byte(randsyms ? 8'($urandom_range(0, 255)) : 8'(s * 37 + 5), 1'b0);
	endtask

	// random valid-ish tree: the last level fills the rest of the code space so codes stay legal
	function automatic void pick_tree(int unsigned depth);
		int unsigned room;
		int unsigned cnt;
		room = 2;
		for (int l = 0; l < depth; l++) begin
			if (l == depth - 1) begin
				cnt = room >= 2 ? room - 2 : 0;
			end else begin
				cnt = $urandom_range(0, room > 1 ? room - 1 : 0);
				if (cnt > 4) cnt = $urandom_range(0, 4);
			end
			gen_counts[l] = cnt;
			room = (room - cnt) * 2;
			if (room > 16) room = 16;
		end
	endfunction

	task automatic test_bad_headers();
		send_byte(8'd0, 1'b1);
		send_byte(8'd25, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h12, 1'b0);
		// too many symbols: 1 + 200 + 100 > 256
		send_byte(8'd2, 1'b1);
		send_byte(8'd200, 1'b0);
		send_byte(8'd100, 1'b0);
		wait_drained();
	endtask

	task automatic test_simple_stream();
		gen_counts[0] = 1;
		gen_counts[1] = 0;
		send_header(2, 1'b0);
		// codes: 1 -> sym0, 00 -> sym1, 01 -> end of block
		send_byte(8'b0100_0010, 1'b0);
		send_byte(8'b0000_0000, 1'b0);
		send_byte(8'b1100_0000, 1'b0);
		send_byte(8'hA5, 1'b0);
		wait_drained();
	endtask

	task automatic test_corrupt_cases();
		// leaf index out of range: depth 2, counts 0 and 0
		gen_counts[0] = 0;
		gen_counts[1] = 0;
		send_header(2, 1'b0);
		send_byte(8'hFF, 1'b0);
		// depth 1, no leaves beyond the two at the last level: 0 decodes sym0, 1 ends the block
		gen_counts[0] = 0;
		send_header(1, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		// deepest tree with the largest depth byte
		for (int l = 0; l < LEVELS; l++) gen_counts[l] = (l == 0) ? 1 : 0;
		send_header(24, 1'b0);
		send_byte(8'h7F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_streams(int unsigned n_bytes);
		int unsigned sent;
		int unsigned depth;
		int unsigned nbytes;
		sent = 0;
		while (sent < n_bytes && !timed_out) begin
			if ($urandom_range(0, 9) == 0) begin
				// noise bytes, possibly broken headers
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					sent++;
				end
			end else begin
				depth = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24)
					: $urandom_range(1, 6);
				pick_tree(depth);
				send_header(depth, 1'b1);
				sent += 1 + depth + gen_nsym;
				nbytes = $urandom_range(2, 12);
				repeat (nbytes) begin
					send_byte(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255)),
						1'b0);
					sent++;
				end
			end
			if ($urandom_range(0, 5) == 0)
				wait_drained();
		end
		wait_drained();
	endtask

	// receiver stalls on its own pattern: long ready stretches and random stall runs
	int stall_run;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			res_ready <= 1'b0;
			stall_run <= stall_run - 1;
		end else begin
			res_ready <= 1'b1;
			if ($urandom_range(0, 15) == 0)
				stall_run <= $urandom_range(1, 9);
		end
	end

	// result checker: compare each accepted item with the oldest expectation
	always @(posedge clk) begin
		res_item_t exp_item;
		if (arst_n && res_valid && res_ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result symbol=%0d status=%0d last=%0b",
						res_item.symbol, res_item.status, res_item.last);
			end else begin
				exp_item = expected_results.pop_front();
				if (res_item !== exp_item) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp sym=%0d st=%0d last=%0b got sym=%0d st=%0d last=%0b",
							exp_item.symbol, exp_item.status, exp_item.last,
							res_item.symbol, res_item.status, res_item.last);
				end
			end
		end
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((byte_valid && byte_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_CAP && !timed_out) begin
			timed_out = 1'b1;
			$display("pack_huffman_stream_decoder_unit_tb failed");
			$finish;
		end
	end

	initial begin
		send_left     = 0;
		send_burst_on = 1'b0;
		dec_phase     = PH_DEPTH;
		dec_last_lvl  = 0;
		dec_lvl_idx   = 0;
		dec_sym_idx   = 0;
		dec_total     = 1;
		dec_code      = 0;
		dec_depth     = 0;
		byte_valid    = 1'b0;
		byte_item     = '0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bad_headers();
		test_simple_stream();
		test_corrupt_cases();
		test_random_streams(230);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("pack_huffman_stream_decoder_unit_tb passed");
		else
			$display("pack_huffman_stream_decoder_unit_tb failed");
		$finish;
	end
endmodule
`default_nettype wire
